### rtl/core/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types and constants of the packet header deframer.
// ----------------------------------------------------------------------------
package phd_pkg;

  localparam int unsigned HdrBytes    = 9;
  localparam int unsigned CountW      = 17;
  localparam logic [16:0] CountMax    = 17'h1FFFF;
  localparam logic [15:0] MaxPayRst   = 16'd1024;
  localparam int unsigned TdataW      = 104;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_BADLEN = 2'd2
  } phd_status_t;

  // one result item
  typedef struct packed {
    logic [15:0] header_checksum;
    logic [15:0] payload_len;
    logic [31:0] seq_number;
    logic [7:0]  pkt_type;
    phd_status_t status;
    logic        done_res;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        has_byte;
  } phd_rec_t;

  // handshake between the queue and the output stage
  typedef struct packed {
    logic valid;
    logic ready;
  } phd_hs_t;

endpackage

### rtl/core/phd_front.sv
// ----------------------------------------------------------------------------
// phd_front
// Counts bytes of a buffer, collects header fields and classifies each byte
// into a payload result, a final result, both or none.
// ----------------------------------------------------------------------------
module phd_front
  import phd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  input  logic        in_tlast,     // end_of_buffer
  input  logic [15:0] max_payload,
  output phd_rec_t    push_rec,
  output logic        push_valid,
  input  logic        push_ready
);

  logic [CountW-1:0] count_r, count_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [15:0]       csum_r, csum_nxt;

  logic              accept;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] idx;
  logic [CountW-1:0] total;
  logic [CountW-1:0] need;
  logic              fwd;
  logic              in_hdr;
  phd_status_t       status;
  logic [7:0]        b;

  assign b         = in_tdata;
  assign pos       = count_r;
  assign in_tready = push_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    type_nxt = type_r;
    seq_nxt  = seq_r;
    len_nxt  = len_r;
    csum_nxt = csum_r;
    priority if (pos == CountW'(0)) begin
      type_nxt = b;
    end else if (pos <= CountW'(4)) begin
      seq_nxt = {seq_r[23:0], b};
    end else if (pos <= CountW'(6)) begin
      len_nxt = {len_r[7:0], b};
    end else if (pos <= CountW'(8)) begin
      csum_nxt = {csum_r[7:0], b};
    end else begin
      // payload byte, header stays as captured
    end
  end

  assign in_hdr = pos < CountW'(HdrBytes);
  assign idx    = pos - CountW'(HdrBytes);
  assign fwd    = !in_hdr && (idx < {1'b0, len_r});
  assign total  = (pos == CountMax) ? CountMax : pos + CountW'(1);
  // length is settled by the time the header's last byte arrives
  assign need   = CountW'(HdrBytes) + {1'b0, len_r};

  always_comb begin
    priority if (total < CountW'(HdrBytes)) begin
      status = ST_SHORT;
    end else if ((len_r > max_payload) || (need > total)) begin
      status = ST_BADLEN;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    push_rec               = '0;
    push_rec.has_byte      = fwd;
    push_rec.done_res      = in_tlast;
    if (fwd) begin
      push_rec.payload_byte  = b;
      push_rec.payload_index = idx[15:0];
    end
    if (in_tlast) begin
      push_rec.status = status;
      if (status != ST_SHORT) begin
        push_rec.pkt_type        = type_nxt;
        push_rec.seq_number      = seq_nxt;
        push_rec.payload_len     = len_nxt;
        push_rec.header_checksum = csum_nxt;
      end
    end
  end

  assign push_valid = accept && (fwd || in_tlast);
  assign count_nxt  = in_tlast ? '0 : total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      type_r  <= '0;
      seq_r   <= '0;
      len_r   <= '0;
      csum_r  <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        count_r <= '0;
        type_r  <= '0;
        seq_r   <= '0;
        len_r   <= '0;
        csum_r  <= '0;
      end else begin
        count_r <= count_nxt;
        type_r  <= type_nxt;
        seq_r   <= seq_nxt;
        len_r   <= len_nxt;
        csum_r  <= csum_nxt;
      end
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> count_r == '0 && len_r == '0)
    else $error("buffer state not cleared after final byte");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tlast && count_r != CountMax |=> count_r == $past(count_r) + CountW'(1))
    else $error("byte count did not advance");

  a_fwd_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_rec.has_byte |-> count_r >= CountW'(HdrBytes))
    else $error("payload byte forwarded inside header");

  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("result pushed into full queue");

endmodule

### rtl/core/phd_queue.sv
// ----------------------------------------------------------------------------
// phd_queue
// Two-entry queue of results between the classifier and the output stage.
// ----------------------------------------------------------------------------
module phd_queue
  import phd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  phd_rec_t push_rec,
  input  logic     push_valid,
  output logic     push_ready,
  output phd_rec_t pop_rec,
  output phd_hs_t  pop_hs_o,
  input  logic     pop_ready
);

  phd_rec_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign push_ready     = count_r != 2'd2;
  assign pop_hs_o.valid = count_r != 2'd0;
  assign pop_hs_o.ready = pop_ready;
  assign push           = push_valid && push_ready;
  assign pop            = pop_hs_o.valid && pop_ready;
  assign pop_rec        = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/core/phd_back.sv
// ----------------------------------------------------------------------------
// phd_back
// Output register: takes results from the queue and presents them on the
// result stream.
// ----------------------------------------------------------------------------
module phd_back
  import phd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  phd_rec_t          pop_rec,
  input  phd_hs_t           pop_hs_i,
  output logic              pop_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [TdataW-1:0] out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  logic     out_valid_r;
  phd_rec_t out_rec_r;
  logic     load;

  assign pop_ready = !out_valid_r || out_tready;
  assign load      = pop_hs_i.valid && pop_hs_i.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_hs_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r <= pop_rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_rec_r.done_res;
  assign out_tuser  = out_rec_r.has_byte;
  assign out_tdata  = {6'd0,
                       out_rec_r.header_checksum,
                       out_rec_r.payload_len,
                       out_rec_r.seq_number,
                       out_rec_r.pkt_type,
                       out_rec_r.status,
                       out_rec_r.payload_index,
                       out_rec_r.payload_byte};

endmodule

### rtl/core/packet_header_deframer.sv
// ----------------------------------------------------------------------------
// packet_header_deframer
// Splits a 9-byte big-endian header off a byte stream, forwards the payload
// and reports header fields and status on the buffer's final byte.
// ----------------------------------------------------------------------------
// path: a result for an accepted byte is written into the result queue, then
//   loaded into the output register and presented on the result stream
// throughput: one byte per cycle unless the result queue is full; the byte
//   counter and classifier header capture update on every accepted byte
// reset: synchronous active-low rst_n clears counters, header fields and the
//   result queue; max_payload returns to 1024; no clearing pass is needed
// ----------------------------------------------------------------------------
module packet_header_deframer
  import phd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [7:0] rx_byte
  input  logic              in_tlast,     // end_of_buffer
  output logic              out_tvalid,
  input  logic              out_tready,
  // [7:0] payload_byte, [23:8] payload_index, [25:24] status,
  // [33:26] pkt_type, [65:34] seq_number, [81:66] payload_len,
  // [97:82] header_checksum, [103:98] zero
  output logic [TdataW-1:0] out_tdata,
  output logic              out_tlast,    // done_res
  output logic              out_tuser,    // has_byte
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [15:0] max_payload_r;
  logic        sel_max;
  phd_rec_t    push_rec;
  logic        push_valid;
  logic        push_ready;
  phd_rec_t    pop_rec;
  phd_hs_t     pop_hs;
  logic        pop_ready;

  assign cfg_pready = 1'b1;
  assign sel_max    = !cfg_paddr[2];
  assign cfg_prdata = sel_max ? {16'd0, max_payload_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MaxPayRst;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_max) begin
      max_payload_r <= cfg_pwdata[15:0];
    end
  end

  phd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .max_payload (max_payload_r),
    .push_rec    (push_rec),
    .push_valid  (push_valid),
    .push_ready  (push_ready)
  );

  phd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_rec   (push_rec),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_rec    (pop_rec),
    .pop_hs_o   (pop_hs),
    .pop_ready  (pop_ready)
  );

  phd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_rec    (pop_rec),
    .pop_hs_i   (pop_hs),
    .pop_ready  (pop_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### sim/tb_packet_header_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_header_deframer
// Streams byte buffers into the deframer, predicts the forwarded payload bytes
// and the final header report for each buffer, and checks every result on the
// output stream against that prediction. Covers short buffers, bad and
// truncated lengths, several max_payload settings and a write to an unmapped
// register.
// ----------------------------------------------------------------------------
module tb_packet_header_deframer;
  import phd_pkg::*;

  localparam logic [2:0] ADDR_MAX_PAYLOAD = 3'd0;
  localparam logic [2:0] ADDR_SPARE       = 3'd4;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold_empty;  // wait for all results before sending this byte
  } rx_req_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [TdataW-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  packet_header_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] limit_reg = MaxPayRst;
  logic [16:0] byte_cnt = '0;
  logic [7:0]  hdr_type = '0;
  logic [31:0] hdr_seq = '0;
  logic [15:0] hdr_len = '0;
  logic [15:0] hdr_csum = '0;

  rx_req_t     rx_q[$];
  phd_rec_t    report_q[$];
  phd_rec_t    want;
  rx_req_t     req;
  int unsigned err_cnt = 0;
  int unsigned bytes_queued = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;
  bit          in_taken = 1'b0;
  bit          hold_pending = 1'b1;

  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one accepted byte: update header capture and queue what it should produce
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    phd_rec_t    r;
    logic [16:0] pos;
    logic [16:0] total;
    logic [16:0] idx;
    bit          fwd;
    r = '0;
    pos = byte_cnt;
    idx = '0;
    fwd = 1'b0;
    if (pos == 0) hdr_type = b;
    else if (pos <= 4) hdr_seq = {hdr_seq[23:0], b};
    else if (pos <= 6) hdr_len = {hdr_len[7:0], b};
    else if (pos <= 8) hdr_csum = {hdr_csum[7:0], b};
    else begin
      idx = pos - 17'(HdrBytes);
      fwd = idx < {1'b0, hdr_len};
    end
    total = (pos < CountMax) ? pos + 17'd1 : CountMax;
    byte_cnt = total;
    if (fwd) begin
      r.has_byte = 1'b1;
      r.payload_byte = b;
      r.payload_index = idx[15:0];
    end
    if (last) begin
      r.done_res = 1'b1;
      if (total < HdrBytes) begin
        r.status = ST_SHORT;
      end else begin
        if (hdr_len > limit_reg || HdrBytes + hdr_len > total) r.status = ST_BADLEN;
        else r.status = ST_OK;
        r.pkt_type = hdr_type;
        r.seq_number = hdr_seq;
        r.payload_len = hdr_len;
        r.header_checksum = hdr_csum;
      end
      byte_cnt = '0;
      hdr_type = '0;
      hdr_seq = '0;
      hdr_len = '0;
      hdr_csum = '0;
    end
    if (fwd || last) report_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // input requests and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        deframe_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          $error("result with nothing pending");
          err_cnt++;
        end else begin
          want = report_q.pop_front();
          check_field("has_byte", want.has_byte, out_tuser);
          check_field("payload_byte", want.payload_byte, out_tdata[7:0]);
          check_field("payload_index", want.payload_index, out_tdata[23:8]);
          check_field("done_res", want.done_res, out_tlast);
          check_field("status", want.status, out_tdata[25:24]);
          check_field("pkt_type", want.pkt_type, out_tdata[33:26]);
          check_field("seq_number", want.seq_number, out_tdata[65:34]);
          check_field("payload_len", want.payload_len, out_tdata[81:66]);
          check_field("header_checksum", want.header_checksum, out_tdata[97:82]);
          check_field("tdata padding", '0, out_tdata[103:98]);
        end
      end
    end
  end

  // byte sender
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (rx_q.size() != 0 && !(rx_q[0].hold_empty && report_q.size() != 0)) begin
        req = rx_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= req.data;
        in_tlast <= req.last;
        send_gap = next_gap(send_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = next_gap(stall_calm);
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_MAX_PAYLOAD) limit_reg = value[15:0];
  endtask

  task automatic wait_idle();
    while (rx_q.size() != 0 || in_tvalid) @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    // bytes that produce no result may still be in flight
    repeat (6) @(posedge clk);
  endtask

  task automatic push_frame(input int unsigned nbytes, input logic [7:0] typ,
                            input logic [31:0] seq, input logic [15:0] len,
                            input logic [15:0] csum, input int hold_at);
    logic [71:0] hdr;
    rx_req_t     r;
    hdr = {typ, seq, len, csum};
    for (int unsigned i = 0; i < nbytes; i++) begin
      r.data = (i < HdrBytes) ? hdr[71 - 8*i -: 8] : 8'($urandom);
      r.last = (i == nbytes - 1);
      r.hold_empty = (hold_at == int'(i));
      rx_q.push_back(r);
    end
    bytes_queued += nbytes;
  endtask

  task automatic push_random_frame();
    int unsigned kind;
    int unsigned nb;
    int          hold_at;
    logic [15:0] len;
    kind = $urandom_range(0, 19);
    len = 16'($urandom_range(0, 24));
    nb = 9 + len + $urandom_range(0, 3);
    if (kind < 2) begin
      nb = $urandom_range(1, 8);
    end else if (kind < 4) begin
      len = 16'($urandom);
      nb = 9 + $urandom_range(0, 20);
    end else if (kind < 6 && len != 0) begin
      nb = 9 + $urandom_range(0, len - 1);
    end else if (kind < 8 && limit_reg <= 40) begin
      len = 16'(limit_reg + $urandom_range(0, 1));
      nb = 9 + len;
    end
    hold_at = -1;
    if (hold_pending || $urandom_range(0, 29) == 0) hold_at = $urandom_range(0, nb - 1);
    hold_pending = 1'b0;
    push_frame(nb, 8'($urandom), $urandom, len, 16'($urandom), hold_at);
  endtask

  initial begin
    logic [15:0] limits[5];
    limits = '{16'd0, 16'd1, 16'd24, 16'($urandom), 16'hFFFF};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-byte buffer, oversized length, then ignored register write
    push_frame(1, 8'hFF, '0, '0, '0, -1);
    push_frame(10, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, -1);
    wait_idle();
    cfg_write(ADDR_SPARE, 32'h0);
    push_frame(12, 8'h00, 32'h0, 16'd2, 16'h0, -1);
    wait_idle();

    foreach (limits[p]) begin
      cfg_write(ADDR_MAX_PAYLOAD, {16'($urandom), limits[p]});
      bytes_queued = 0;
      while (bytes_queued < 310) push_random_frame();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
